// File: hdl/ert_pkg.sv
// ert_pkg: shared types, status codes and arithmetic constants of the echo reply tracker
// used by every module of the tracker and by its port checker
// no dependencies

package ert_pkg;

    // field widths
    localparam int SEQ_W    = 16;
    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int CNT_W    = 32;
    localparam int LEN_W    = 16;
    localparam int HDR_W    = 4;
    localparam int TYPE_W   = 8;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // default duplicate window (bits in the seen map)
    localparam int DUP_WINDOW_DEF = 1024;

    // time arithmetic
    localparam int          UDIFF_W      = USEC_W + 1;
    localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
    localparam logic [31:0] MS_PER_SEC   = 32'd1000;
    // usec / 1000 as (usec * ceil(2^30 / 1000)) >> 30, exact for 20-bit magnitudes
    localparam int          RECIP_SHIFT  = 30;
    localparam int          RECIP_W      = 21;
    localparam logic [20:0] RECIP_MS     = 21'd1073742;
    localparam int          QPROD_W      = USEC_W + RECIP_W;
    localparam int          QUOT_W       = 11;

    // shortest acceptable reply beyond the IP header, in bytes
    localparam logic [LEN_W-1:0] MIN_LEN_BASE = 16'd8;

    localparam logic [31:0] RTT_MIN_INIT = 32'h7fff_ffff;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_SENT    = 3'd0,
        ST_NEW     = 3'd1,
        ST_DUP     = 3'd2,
        ST_SHORT   = 3'd3,
        ST_TYPE    = 3'd4,
        ST_FOREIGN = 3'd5
    } status_t;

    // operation codes
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMING   = 1'b1;

    // one accepted input word
    typedef struct packed {
        logic              op;
        logic [LEN_W-1:0]  pkt_len;
        logic [HDR_W-1:0]  header_words;
        logic [TYPE_W-1:0] msg_type;
        logic [ID_W-1:0]   reply_id;
        logic [SEQ_W-1:0]  reply_seq;
        logic [SEC_W-1:0]  sent_sec;
        logic [USEC_W-1:0] sent_usec;
        logic [SEC_W-1:0]  now_sec;
        logic [USEC_W-1:0] now_usec;
    } in_item_t;

    // word handed from the trip pipeline to the statistics stage
    typedef struct packed {
        status_t          cls;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] slot;
        logic [31:0]      trip;
    } trip_item_t;

    // seen map read request
    typedef struct packed {
        logic             en;
        logic [SEQ_W-1:0] addr;
    } map_rd_t;

    // seen map write request
    typedef struct packed {
        logic             en;
        logic [SEQ_W-1:0] addr;
        logic             data;
    } map_wr_t;

endpackage

// File: hdl/ert_trip_pipe.sv
// ert_trip_pipe: four-stage front pipeline that classifies a word, works out the
// round-trip milliseconds and the seen map slot, and issues the map read
// depends on ert_pkg

module ert_trip_pipe #(
    parameter int DUP_WINDOW = ert_pkg::DUP_WINDOW_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ert_pkg::in_item_t            in_item,
    input  logic [ert_pkg::ID_W-1:0]     local_id,
    output logic                         d_valid,
    input  logic                         d_ready,
    output ert_pkg::trip_item_t          d_item,
    output ert_pkg::map_rd_t             map_rd
);

    localparam int SLOT_W = $clog2(DUP_WINDOW);
    // seq / DUP_WINDOW as (seq * ceil(2^32 / DUP_WINDOW)) >> 32, exact for 16-bit seq
    localparam logic [32:0] MOD_MUL =
        33'(((64'd1 << 32) + 64'(DUP_WINDOW) - 64'd1) / 64'(DUP_WINDOW));

    // stage a: accepted word
    logic                 a_vld_reg;
    ert_pkg::in_item_t    a_item_reg;

    // stage b: class, time differences, slot quotient
    logic                            b_vld_reg;
    ert_pkg::status_t                b_cls_reg;
    logic [ert_pkg::SEQ_W-1:0]       b_seq_reg;
    logic [31:0]                     b_sd_reg;
    logic                            b_neg_reg;
    logic [ert_pkg::USEC_W-1:0]      b_mag_reg;
    logic [ert_pkg::SEQ_W-1:0]       b_modq_reg;

    // stage c: scaled seconds, signed ms of the usec part, slot
    logic                            c_vld_reg;
    ert_pkg::status_t                c_cls_reg;
    logic [ert_pkg::SEQ_W-1:0]       c_seq_reg;
    logic [SLOT_W-1:0]               c_slot_reg;
    logic [31:0]                     c_sdk_reg;
    logic [ert_pkg::QUOT_W:0]        c_q_reg;

    // stage d
    logic                            d_vld_reg;
    ert_pkg::trip_item_t             d_item_reg;

    logic d_free;
    logic c_free;
    logic b_free;
    logic a_free;

    // a -> b
    logic [ert_pkg::UDIFF_W-1:0] ud_diff;
    logic [ert_pkg::UDIFF_W-1:0] ud_adj;
    logic [ert_pkg::UDIFF_W-1:0] ud_neg;
    logic                        borrow;
    logic [31:0]                 sd;
    logic [ert_pkg::LEN_W-1:0]   min_len;
    logic [48:0]                 mod_prod;
    ert_pkg::status_t            cls;

    // b -> c
    logic [ert_pkg::QPROD_W-1:0] q_prod;
    logic [ert_pkg::QUOT_W-1:0]  q_mag;
    logic [ert_pkg::QUOT_W:0]    q_signed;
    logic [31:0]                 sdk;
    logic [31:0]                 q_times_w;
    logic [31:0]                 slot_full;

    // c -> d
    logic [31:0]                 trip;

    // stage handshake, back to front
    assign d_free   = !d_vld_reg || d_ready;
    assign c_free   = !c_vld_reg || d_free;
    assign b_free   = !b_vld_reg || c_free;
    assign a_free   = !a_vld_reg || b_free;
    assign in_ready = a_free;

    always_comb
    begin
        ud_diff = {1'b0, a_item_reg.now_usec} - {1'b0, a_item_reg.sent_usec};
        borrow  = ud_diff[ert_pkg::UDIFF_W-1];
        ud_adj  = borrow ? ud_diff + ert_pkg::USEC_PER_SEC : ud_diff;
        ud_neg  = -ud_adj;
        sd      = a_item_reg.now_sec - a_item_reg.sent_sec - 32'(borrow);
        min_len = 16'({a_item_reg.header_words, 2'b00}) + ert_pkg::MIN_LEN_BASE;
        mod_prod = 49'(a_item_reg.reply_seq) * 49'(MOD_MUL);

        if (a_item_reg.op == ert_pkg::OP_SEND)
            cls = ert_pkg::ST_SENT;
        else if (a_item_reg.pkt_len < min_len)
            cls = ert_pkg::ST_SHORT;
        else if (a_item_reg.msg_type != '0)
            cls = ert_pkg::ST_TYPE;
        else if (a_item_reg.reply_id != local_id)
            cls = ert_pkg::ST_FOREIGN;
        else
            cls = ert_pkg::ST_NEW;
    end

    always_comb
    begin
        q_prod    = ert_pkg::QPROD_W'(b_mag_reg) * ert_pkg::QPROD_W'(ert_pkg::RECIP_MS);
        q_mag     = q_prod[ert_pkg::RECIP_SHIFT +: ert_pkg::QUOT_W];
        q_signed  = b_neg_reg ? -{1'b0, q_mag} : {1'b0, q_mag};
        sdk       = b_sd_reg * ert_pkg::MS_PER_SEC;
        q_times_w = 32'(b_modq_reg) * 32'(DUP_WINDOW);
        slot_full = 32'(b_seq_reg) - q_times_w;
    end

    assign trip = c_sdk_reg + {{(32 - ert_pkg::QUOT_W - 1){c_q_reg[ert_pkg::QUOT_W]}}, c_q_reg};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_vld_reg <= in_valid;
            if (b_free)
                b_vld_reg <= a_vld_reg;
            if (c_free)
                c_vld_reg <= b_vld_reg;
            if (d_free)
                d_vld_reg <= c_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
            a_item_reg <= in_item;
        if (b_free && a_vld_reg)
        begin
            b_cls_reg  <= cls;
            b_seq_reg  <= a_item_reg.reply_seq;
            b_sd_reg   <= sd;
            b_neg_reg  <= ud_adj[ert_pkg::UDIFF_W-1];
            b_mag_reg  <= ud_adj[ert_pkg::UDIFF_W-1] ? ud_neg[ert_pkg::USEC_W-1:0]
                                                      : ud_adj[ert_pkg::USEC_W-1:0];
            b_modq_reg <= mod_prod[32 +: ert_pkg::SEQ_W];
        end
        if (c_free && b_vld_reg)
        begin
            c_cls_reg  <= b_cls_reg;
            c_seq_reg  <= b_seq_reg;
            c_slot_reg <= slot_full[SLOT_W-1:0];
            c_sdk_reg  <= sdk;
            c_q_reg    <= q_signed;
        end
        if (d_free && c_vld_reg)
        begin
            d_item_reg.cls  <= c_cls_reg;
            d_item_reg.seq  <= c_seq_reg;
            d_item_reg.slot <= ert_pkg::SEQ_W'(c_slot_reg);
            d_item_reg.trip <= trip;
        end
    end

    // map read goes out as the word enters stage d
    assign map_rd.en   = c_vld_reg && d_free;
    assign map_rd.addr = ert_pkg::SEQ_W'(c_slot_reg);

    assign d_valid = d_vld_reg;
    assign d_item  = d_item_reg;

endmodule

// File: hdl/ert_seen_map.sv
// ert_seen_map: bitmap of received sequence slots with a registered read port,
// write-to-read forwarding and a clearing sweep after reset
// depends on ert_pkg

module ert_seen_map #(
    parameter int DUP_WINDOW = ert_pkg::DUP_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ert_pkg::map_rd_t  map_rd,
    input  ert_pkg::map_wr_t  map_wr,
    output logic              rd_bit,
    output logic              busy
);

    localparam int SLOT_W = $clog2(DUP_WINDOW);

    logic              seen_mem [DUP_WINDOW];
    logic              rd_bit_reg;
    logic              busy_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SLOT_W'(DUP_WINDOW - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            seen_mem[clr_cnt_reg] <= 1'b0;
        else if (map_wr.en)
            seen_mem[map_wr.addr[SLOT_W-1:0]] <= map_wr.data;

        // the word accepted by the statistics stage writes on the same edge
        if (map_rd.en)
        begin
            if (map_wr.en && (map_wr.addr == map_rd.addr))
                rd_bit_reg <= map_wr.data;
            else
                rd_bit_reg <= seen_mem[map_rd.addr[SLOT_W-1:0]];
        end
    end

    assign rd_bit = rd_bit_reg;
    assign busy   = busy_reg;

endmodule

// File: hdl/ert_stats.sv
// ert_stats: counters, round-trip statistics and the result register; decides
// new against duplicate and writes the seen map
// depends on ert_pkg

module ert_stats #(
    parameter int DUP_WINDOW = ert_pkg::DUP_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          d_valid,
    output logic                          d_ready,
    input  ert_pkg::trip_item_t           d_item,
    input  logic                          seen_bit,
    input  logic                          timing_enable,
    output ert_pkg::map_wr_t              map_wr,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ert_pkg::STATUS_W-1:0]  status,
    output logic [ert_pkg::SEQ_W-1:0]     seq_out,
    output logic [31:0]                   trip_ms,
    output logic [ert_pkg::CNT_W-1:0]     sent_count,
    output logic [ert_pkg::CNT_W-1:0]     recv_count,
    output logic [ert_pkg::CNT_W-1:0]     dup_count,
    output logic [31:0]                   min_rtt,
    output logic [31:0]                   max_rtt,
    output logic [31:0]                   rtt_sum
);

    localparam int SLOT_W = $clog2(DUP_WINDOW);

    logic                          out_vld_reg;
    ert_pkg::status_t              status_reg;
    ert_pkg::status_t              status_next;
    logic [ert_pkg::SEQ_W-1:0]     seq_reg;
    logic [ert_pkg::SEQ_W-1:0]     seq_next;
    logic [31:0]                   trip_reg;
    logic [31:0]                   trip_next;

    logic [ert_pkg::CNT_W-1:0]     sent_reg;
    logic [ert_pkg::CNT_W-1:0]     sent_next;
    logic [ert_pkg::CNT_W-1:0]     recv_reg;
    logic [ert_pkg::CNT_W-1:0]     recv_next;
    logic [ert_pkg::CNT_W-1:0]     dup_reg;
    logic [ert_pkg::CNT_W-1:0]     dup_next;
    logic [31:0]                   min_reg;
    logic [31:0]                   min_next;
    logic [31:0]                   max_reg;
    logic [31:0]                   max_next;
    logic [31:0]                   sum_reg;
    logic [31:0]                   sum_next;
    logic [SLOT_W-1:0]             send_slot_reg;
    logic [SLOT_W-1:0]             send_slot_next;

    logic fire;
    logic is_send;
    logic good;
    logic timed;
    logic dup;

    assign d_ready = !out_vld_reg || !out_stall;
    assign fire    = d_valid && d_ready;

    always_comb
    begin
        is_send = (d_item.cls == ert_pkg::ST_SENT);
        good    = (d_item.cls == ert_pkg::ST_NEW);
        timed   = good && timing_enable;
        dup     = good && seen_bit;

        sent_next      = sent_reg;
        send_slot_next = send_slot_reg;
        recv_next      = recv_reg;
        dup_next       = dup_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        seq_next       = d_item.seq;
        trip_next      = '0;
        status_next    = d_item.cls;

        if (is_send)
        begin
            seq_next  = sent_reg[ert_pkg::SEQ_W-1:0];
            sent_next = sent_reg + 1'b1;
            // slot follows the 16-bit sequence number modulo the window
            if ((sent_reg[ert_pkg::SEQ_W-1:0] == '1) ||
                (send_slot_reg == SLOT_W'(DUP_WINDOW - 1)))
                send_slot_next = '0;
            else
                send_slot_next = send_slot_reg + 1'b1;
        end

        if (timed)
        begin
            trip_next = d_item.trip;
            sum_next  = sum_reg + d_item.trip;
            if ($signed(d_item.trip) < $signed(min_reg))
                min_next = d_item.trip;
            if ($signed(d_item.trip) > $signed(max_reg))
                max_next = d_item.trip;
        end

        if (good)
        begin
            if (dup)
            begin
                dup_next    = dup_reg + 1'b1;
                status_next = ert_pkg::ST_DUP;
            end
            else
            begin
                recv_next   = recv_reg + 1'b1;
                status_next = ert_pkg::ST_NEW;
            end
        end

        map_wr.en   = fire && (is_send || (good && !seen_bit));
        map_wr.addr = is_send ? ert_pkg::SEQ_W'(send_slot_reg) : d_item.slot;
        map_wr.data = !is_send;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            sent_reg      <= '0;
            recv_reg      <= '0;
            dup_reg       <= '0;
            min_reg       <= ert_pkg::RTT_MIN_INIT;
            max_reg       <= '0;
            sum_reg       <= '0;
            send_slot_reg <= '0;
        end
        else
        begin
            if (d_ready)
                out_vld_reg <= d_valid;
            if (fire)
            begin
                sent_reg      <= sent_next;
                recv_reg      <= recv_next;
                dup_reg       <= dup_next;
                min_reg       <= min_next;
                max_reg       <= max_next;
                sum_reg       <= sum_next;
                send_slot_reg <= send_slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            seq_reg    <= seq_next;
            trip_reg   <= trip_next;
        end
    end

    // totals change only on fire, so they always match the word on show
    assign out_valid  = out_vld_reg;
    assign status     = status_reg;
    assign seq_out    = seq_reg;
    assign trip_ms    = trip_reg;
    assign sent_count = sent_reg;
    assign recv_count = recv_reg;
    assign dup_count  = dup_reg;
    assign min_rtt    = min_reg;
    assign max_rtt    = max_reg;
    assign rtt_sum    = sum_reg;

endmodule

// File: hdl/echo_reply_tracker.sv
// echo_reply_tracker: top level of the echo exchange tracker
// depends on ert_pkg, ert_trip_pipe, ert_seen_map and ert_stats

// Echo exchange tracker. Each input word is a send event (op 0) or a received
// packet (op 1) and yields exactly one result word. A send hands out the next
// 16-bit sequence number and clears its slot in the seen map; a received packet
// is checked for length, message type and identifier, and a good reply updates
// the round-trip figures (when timing is enabled) and is counted as new or as a
// duplicate. Throughput is one word per clock while no stall holds the flow; a
// word is registered on entry and passes three arithmetic stages of the trip
// pipeline (holding the 32x32 seconds scaling and the reciprocal multiplies),
// then the statistics stage that updates the totals and the seen map. After reset
// the seen map is cleared one slot per cycle, and in_stall stays high until every
// slot is clear; configuration writes are taken at any time (cfg_ready is tied
// high) but must only be issued while the tracker is idle. The totals shown with
// a result are those after that word; all counters and the round-trip sum wrap.

module echo_reply_tracker #(
    parameter int DUP_WINDOW = ert_pkg::DUP_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // input words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [ert_pkg::LEN_W-1:0]         pkt_len,
    input  logic [ert_pkg::HDR_W-1:0]         header_words,
    input  logic [ert_pkg::TYPE_W-1:0]        msg_type,
    input  logic [ert_pkg::ID_W-1:0]          reply_id,
    input  logic [ert_pkg::SEQ_W-1:0]         reply_seq,
    input  logic [ert_pkg::SEC_W-1:0]         sent_sec,
    input  logic [ert_pkg::USEC_W-1:0]        sent_usec,
    input  logic [ert_pkg::SEC_W-1:0]         now_sec,
    input  logic [ert_pkg::USEC_W-1:0]        now_usec,

    // result words
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ert_pkg::STATUS_W-1:0]      status,
    output logic [ert_pkg::SEQ_W-1:0]         seq_out,
    output logic signed [31:0]                trip_ms,
    output logic [ert_pkg::CNT_W-1:0]         sent_count,
    output logic [ert_pkg::CNT_W-1:0]         recv_count,
    output logic [ert_pkg::CNT_W-1:0]         dup_count,
    output logic signed [31:0]                min_rtt,
    output logic signed [31:0]                max_rtt,
    output logic [31:0]                       rtt_sum,

    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ert_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ert_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic [ert_pkg::ID_W-1:0] local_id_reg;
    logic                     timing_enable_reg;

    ert_pkg::in_item_t        in_item;
    logic                     pipe_in_valid;
    logic                     pipe_in_ready;
    logic                     map_busy;

    logic                     d_valid;
    logic                     d_ready;
    ert_pkg::trip_item_t      d_item;
    ert_pkg::map_rd_t         map_rd;
    ert_pkg::map_wr_t         map_wr;
    logic                     seen_bit;

    logic [31:0]              trip_raw;
    logic [31:0]              min_raw;
    logic [31:0]              max_raw;

    // register writes: always ready, one word per cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg      <= '0;
            timing_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ert_pkg::REG_LOCAL_ID: local_id_reg      <= cfg_data;
                ert_pkg::REG_TIMING:   timing_enable_reg <= cfg_data[0];
            endcase
        end
    end

    // gather the input fields into one word
    always_comb
    begin
        in_item.op           = op;
        in_item.pkt_len      = pkt_len;
        in_item.header_words = header_words;
        in_item.msg_type     = msg_type;
        in_item.reply_id     = reply_id;
        in_item.reply_seq    = reply_seq;
        in_item.sent_sec     = sent_sec;
        in_item.sent_usec    = sent_usec;
        in_item.now_sec      = now_sec;
        in_item.now_usec     = now_usec;
    end

    // no word enters while the seen map is being cleared
    assign pipe_in_valid = in_valid && !map_busy;
    assign in_stall      = map_busy || !pipe_in_ready;

    ert_trip_pipe #(
        .DUP_WINDOW (DUP_WINDOW)
    ) u_trip_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_in_valid),
        .in_ready (pipe_in_ready),
        .in_item  (in_item),
        .local_id (local_id_reg),
        .d_valid  (d_valid),
        .d_ready  (d_ready),
        .d_item   (d_item),
        .map_rd   (map_rd)
    );

    ert_seen_map #(
        .DUP_WINDOW (DUP_WINDOW)
    ) u_seen_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .map_rd (map_rd),
        .map_wr (map_wr),
        .rd_bit (seen_bit),
        .busy   (map_busy)
    );

    ert_stats #(
        .DUP_WINDOW (DUP_WINDOW)
    ) u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .d_valid       (d_valid),
        .d_ready       (d_ready),
        .d_item        (d_item),
        .seen_bit      (seen_bit),
        .timing_enable (timing_enable_reg),
        .map_wr        (map_wr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .seq_out       (seq_out),
        .trip_ms       (trip_raw),
        .sent_count    (sent_count),
        .recv_count    (recv_count),
        .dup_count     (dup_count),
        .min_rtt       (min_raw),
        .max_rtt       (max_raw),
        .rtt_sum       (rtt_sum)
    );

    // round-trip figures are two's complement on the ports
    assign trip_ms = $signed(trip_raw);
    assign min_rtt = $signed(min_raw);
    assign max_rtt = $signed(max_raw);

endmodule

// File: hdl/ert_checker.sv
// ert_checker: port-level checks of the echo reply tracker, bound to the top level
// depends on ert_pkg and echo_reply_tracker

module ert_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ert_pkg::STATUS_W-1:0]  status,
    input  logic [ert_pkg::SEQ_W-1:0]     seq_out,
    input  logic signed [31:0]            trip_ms,
    input  logic [ert_pkg::CNT_W-1:0]     sent_count,
    input  logic signed [31:0]            min_rtt,
    input  logic signed [31:0]            max_rtt
);

    // a held result word keeps its sequence number
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(seq_out))
        else $error("result word dropped or changed while stalled");

    // a send shows the number handed out, one below the updated send count
    a_send_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ert_pkg::ST_SENT) |->
            seq_out == ert_pkg::SEQ_W'(sent_count - 1'b1))
        else $error("send sequence number does not follow the send count");

    // only good replies carry a round-trip time
    a_trip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ert_pkg::ST_NEW) && (status != ert_pkg::ST_DUP) |->
            trip_ms == '0)
        else $error("round-trip time on a send or rejected packet");

    // a nonzero reported round-trip time lies within the updated extremes
    a_trip_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (trip_ms != '0) |-> (min_rtt <= trip_ms) && (trip_ms <= max_rtt))
        else $error("round-trip time outside min and max");

endmodule

bind echo_reply_tracker ert_checker u_ert_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .seq_out    (seq_out),
    .trip_ms    (trip_ms),
    .sent_count (sent_count),
    .min_rtt    (min_rtt),
    .max_rtt    (max_rtt)
);

// File: sim/tb_echo_reply_tracker.sv
// tb_echo_reply_tracker: self-checking bench for the echo reply tracker
// depends on ert_pkg and echo_reply_tracker; a scoreboard class predicts every result word

module tb_echo_reply_tracker;

    localparam int WINDOW = ert_pkg::DUP_WINDOW_DEF;
    // watchdog bound on a correct run, the map sweep after reset included
    localparam int LIMIT  = 40000;

    // one result word as seen on the output ports
    typedef struct packed {
        logic [ert_pkg::STATUS_W-1:0] status;
        logic [ert_pkg::SEQ_W-1:0]    seq;
        logic [31:0]                  trip;
        logic [ert_pkg::CNT_W-1:0]    sent;
        logic [ert_pkg::CNT_W-1:0]    recv;
        logic [ert_pkg::CNT_W-1:0]    dup;
        logic [31:0]                  lo;
        logic [31:0]                  hi;
        logic [31:0]                  sum;
    } outcome_t;

    // predicts the tracker word by word and checks its results in order
    class reply_scoreboard;
        bit                        seen [WINDOW];
        logic [ert_pkg::CNT_W-1:0] n_sent;
        logic [ert_pkg::CNT_W-1:0] n_recv;
        logic [ert_pkg::CNT_W-1:0] n_dup;
        logic [31:0]               rtt_lo;
        logic [31:0]               rtt_hi;
        logic [31:0]               rtt_acc;
        logic [ert_pkg::ID_W-1:0]  our_id;
        bit                        timing_on;
        outcome_t                  awaited [$];
        int                        errors;

        function new();
            foreach (seen[i]) seen[i] = 1'b0;
            n_sent    = '0;
            n_recv    = '0;
            n_dup     = '0;
            rtt_lo    = ert_pkg::RTT_MIN_INIT;
            rtt_hi    = '0;
            rtt_acc   = '0;
            our_id    = '0;
            timing_on = 1'b1;
            errors    = 0;
        endfunction

        function void set_reg(logic [ert_pkg::CFG_IDX_W-1:0] idx,
                              logic [ert_pkg::CFG_DATA_W-1:0] d);
            if (idx == ert_pkg::REG_LOCAL_ID)
                our_id = d[ert_pkg::ID_W-1:0];
            else if (idx == ert_pkg::REG_TIMING)
                timing_on = d[0];
        endfunction

        // sec*1000 + usec/1000 with a one-second borrow, wrapping to 32 bits
        function logic [31:0] round_trip(ert_pkg::in_item_t w);
            int          ud;
            logic [31:0] sd;
            int          q;
            ud = int'(w.now_usec) - int'(w.sent_usec);
            sd = w.now_sec;
            if (ud < 0)
            begin
                sd = sd - 32'd1;
                ud = ud + 1000000;
            end
            sd = sd - w.sent_sec;
            q  = ud / 1000;
            return sd * 32'd1000 + 32'(q);
        endfunction

        function void note_word(ert_pkg::in_item_t w);
            outcome_t e;
            int       slot;
            int       min_len;
            e = '0;
            if (w.op == ert_pkg::OP_SEND)
            begin
                e.seq  = n_sent[ert_pkg::SEQ_W-1:0];
                n_sent = n_sent + 1;
                seen[int'(e.seq) % WINDOW] = 1'b0;
                e.status = ert_pkg::ST_SENT;
            end
            else
            begin
                e.seq   = w.reply_seq;
                min_len = int'(w.header_words) * 4 + 8;
                if (int'(w.pkt_len) < min_len)
                    e.status = ert_pkg::ST_SHORT;
                else if (w.msg_type != '0)
                    e.status = ert_pkg::ST_TYPE;
                else if (w.reply_id != our_id)
                    e.status = ert_pkg::ST_FOREIGN;
                else
                begin
                    slot = int'(w.reply_seq) % WINDOW;
                    if (timing_on)
                    begin
                        e.trip  = round_trip(w);
                        rtt_acc = rtt_acc + e.trip;
                        if ($signed(e.trip) < $signed(rtt_lo))
                            rtt_lo = e.trip;
                        if ($signed(e.trip) > $signed(rtt_hi))
                            rtt_hi = e.trip;
                    end
                    if (seen[slot])
                    begin
                        n_dup    = n_dup + 1;
                        e.status = ert_pkg::ST_DUP;
                    end
                    else
                    begin
                        seen[slot] = 1'b1;
                        n_recv     = n_recv + 1;
                        e.status   = ert_pkg::ST_NEW;
                    end
                end
            end
            e.sent = n_sent;
            e.recv = n_recv;
            e.dup  = n_dup;
            e.lo   = rtt_lo;
            e.hi   = rtt_hi;
            e.sum  = rtt_acc;
            awaited.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string f, logic [31:0] e, logic [31:0] g);
            if (g !== e)
                report($sformatf("%s expected 0x%08h got 0x%08h", f, e, g));
        endtask

        task check_word(outcome_t got);
            outcome_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("result word with none pending, status %0d seq %0d",
                                 got.status, got.seq));
                return;
            end
            e = awaited.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("seq_out", e.seq, got.seq);
            compare_field("trip_ms", e.trip, got.trip);
            compare_field("sent_count", e.sent, got.sent);
            compare_field("recv_count", e.recv, got.recv);
            compare_field("dup_count", e.dup, got.dup);
            compare_field("min_rtt", e.lo, got.lo);
            compare_field("max_rtt", e.hi, got.hi);
            compare_field("rtt_sum", e.sum, got.sum);
        endtask
    endclass

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic                           op           = ert_pkg::OP_SEND;
    logic [ert_pkg::LEN_W-1:0]      pkt_len      = '0;
    logic [ert_pkg::HDR_W-1:0]      header_words = '0;
    logic [ert_pkg::TYPE_W-1:0]     msg_type     = '0;
    logic [ert_pkg::ID_W-1:0]       reply_id     = '0;
    logic [ert_pkg::SEQ_W-1:0]      reply_seq    = '0;
    logic [ert_pkg::SEC_W-1:0]      sent_sec     = '0;
    logic [ert_pkg::USEC_W-1:0]     sent_usec    = '0;
    logic [ert_pkg::SEC_W-1:0]      now_sec      = '0;
    logic [ert_pkg::USEC_W-1:0]     now_usec     = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic [ert_pkg::STATUS_W-1:0]   status;
    logic [ert_pkg::SEQ_W-1:0]      seq_out;
    logic signed [31:0]             trip_ms;
    logic [ert_pkg::CNT_W-1:0]      sent_count;
    logic [ert_pkg::CNT_W-1:0]      recv_count;
    logic [ert_pkg::CNT_W-1:0]      dup_count;
    logic signed [31:0]             min_rtt;
    logic signed [31:0]             max_rtt;
    logic [31:0]                    rtt_sum;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [ert_pkg::CFG_IDX_W-1:0]  cfg_index    = ert_pkg::REG_LOCAL_ID;
    logic [ert_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    reply_scoreboard sb = new();

    // stimulus bookkeeping
    int                 sends_issued = 0;
    logic [15:0]        cur_id       = '0;
    bit                 quiet        = 1'b0;
    ert_pkg::in_item_t  last_good;
    bit                 have_good    = 1'b0;
    int unsigned        cycles       = 0;

    echo_reply_tracker #(.DUP_WINDOW(WINDOW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .pkt_len      (pkt_len),
        .header_words (header_words),
        .msg_type     (msg_type),
        .reply_id     (reply_id),
        .reply_seq    (reply_seq),
        .sent_sec     (sent_sec),
        .sent_usec    (sent_usec),
        .now_sec      (now_sec),
        .now_usec     (now_usec),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .seq_out      (seq_out),
        .trip_ms      (trip_ms),
        .sent_count   (sent_count),
        .recv_count   (recv_count),
        .dup_count    (dup_count),
        .min_rtt      (min_rtt),
        .max_rtt      (max_rtt),
        .rtt_sum      (rtt_sum),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check each accepted word, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word('{status, seq_out, trip_ms, sent_count, recv_count, dup_count,
                            min_rtt, max_rtt, rtt_sum});
        out_stall <= !quiet && ($urandom_range(99) < 32);
    end

    // hand one word to the tracker, with random idle cycles in front of it unless quiet is set
    task push_word(input ert_pkg::in_item_t w);
        if (!quiet)
            while ($urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid     <= 1'b1;
        op           <= w.op;
        pkt_len      <= w.pkt_len;
        header_words <= w.header_words;
        msg_type     <= w.msg_type;
        reply_id     <= w.reply_id;
        reply_seq    <= w.reply_seq;
        sent_sec     <= w.sent_sec;
        sent_usec    <= w.sent_usec;
        now_sec      <= w.now_sec;
        now_usec     <= w.now_usec;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
    endtask

    // hold the sender off until every pending result has come back
    task drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write both registers back to back, only while the tracker is idle
    task write_regs(input logic [ert_pkg::CFG_DATA_W-1:0] id_val,
                    input logic [ert_pkg::CFG_DATA_W-1:0] tim_val);
        logic [ert_pkg::CFG_IDX_W-1:0]  idx;
        logic [ert_pkg::CFG_DATA_W-1:0] d;
        for (int i = 0; i < 2; i++)
        begin
            idx = (i == 0) ? ert_pkg::REG_LOCAL_ID : ert_pkg::REG_TIMING;
            d   = (i == 0) ? id_val : tim_val;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(idx, d);
        end
        cfg_valid <= 1'b0;
        cur_id = id_val;
    endtask

    function ert_pkg::in_item_t junk();
        ert_pkg::in_item_t w;
        w.op           = 1'($urandom);
        w.pkt_len      = 16'($urandom);
        w.header_words = 4'($urandom);
        w.msg_type     = 8'($urandom);
        w.reply_id     = 16'($urandom);
        w.reply_seq    = 16'($urandom);
        w.sent_sec     = $urandom;
        w.sent_usec    = 20'($urandom);
        w.now_sec      = $urandom;
        w.now_usec     = 20'($urandom);
        return w;
    endfunction

    // send event; the payload fields carry noise that the tracker must ignore
    function ert_pkg::in_item_t next_send();
        ert_pkg::in_item_t w;
        w    = junk();
        w.op = ert_pkg::OP_SEND;
        sends_issued++;
        return w;
    endfunction

    function ert_pkg::in_item_t mk_reply(logic [15:0] seq, logic [15:0] id, logic [7:0] typ,
                                         logic [3:0] hdr, logic [15:0] len,
                                         logic [31:0] ssec, logic [19:0] susec,
                                         logic [31:0] nsec, logic [19:0] nusec);
        ert_pkg::in_item_t w;
        w.op           = ert_pkg::OP_RECV;
        w.pkt_len      = len;
        w.header_words = hdr;
        w.msg_type     = typ;
        w.reply_id     = id;
        w.reply_seq    = seq;
        w.sent_sec     = ssec;
        w.sent_usec    = susec;
        w.now_sec      = nsec;
        w.now_usec     = nusec;
        return w;
    endfunction

    // mostly a recent sequence number, sometimes an alias whole windows away or a stray one
    function logic [15:0] pick_seq();
        int          back;
        logic [15:0] s;
        if (sends_issued == 0 || $urandom_range(9) == 0)
            return 16'($urandom);
        back = (sends_issued - 1 < 12) ? sends_issued - 1 : 12;
        s    = 16'(sends_issued - 1 - int'($urandom_range(0, back)));
        if ($urandom_range(7) == 0)
            s = s + 16'(WINDOW * int'($urandom_range(1, 63)));
        return s;
    endfunction

    // well-formed reply with a plausible timestamp, at times late or out of range
    function ert_pkg::in_item_t timed_reply(logic [15:0] seq);
        int          hdr;
        int          base;
        int          len;
        int          nus;
        int          sus;
        logic [31:0] nsec;
        logic [31:0] ssec;
        logic [31:0] swap_sec;
        int          swap_us;
        hdr  = $urandom_range(0, 15);
        base = hdr * 4 + 8;
        if ($urandom_range(3) == 0)
            len = $urandom_range(base, 65535);
        else
            len = $urandom_range(base, base + 64);
        nsec = $urandom;
        nus  = $urandom_range(0, 999999);
        ssec = nsec - (($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2));
        sus  = nus - int'($urandom_range(0, 999999));
        if (sus < 0)
        begin
            sus  = sus + 1000000;
            ssec = ssec - 32'd1;
        end
        // late timestamp: send time after reception
        if ($urandom_range(11) == 0)
        begin
            swap_sec = ssec;
            swap_us  = sus;
            ssec     = nsec;
            sus      = nus;
            nsec     = swap_sec;
            nus      = swap_us;
        end
        if ($urandom_range(15) == 0)
            sus = $urandom_range(1000000, 1048575);
        if ($urandom_range(15) == 0)
            nus = $urandom_range(1000000, 1048575);
        return mk_reply(seq, cur_id, 8'd0, 4'(hdr), 16'(len), ssec, 20'(sus), nsec, 20'(nus));
    endfunction

    function ert_pkg::in_item_t random_word();
        int                r;
        int                base;
        ert_pkg::in_item_t w;
        r = $urandom_range(99);
        if (r < 28)
            return next_send();
        if (r < 76 && have_good && r >= 68)
            return last_good;
        w = timed_reply(pick_seq());
        if (r < 76)
        begin
            last_good = w;
            have_good = 1'b1;
            return w;
        end
        // broken replies and noise
        case ($urandom_range(3))
            0:
            begin
                base      = int'(w.header_words) * 4 + 8;
                w.pkt_len = 16'($urandom_range(0, base - 1));
            end
            1: w.msg_type = 8'($urandom_range(1, 255));
            2: w.reply_id = cur_id ^ 16'($urandom_range(1, 65535));
            default:
            begin
                w    = junk();
                w.op = ert_pkg::OP_RECV;
                if ($urandom_range(1) == 0)
                begin
                    w.msg_type = 8'd0;
                    w.reply_id = cur_id;
                end
            end
        endcase
        return w;
    endfunction

    task random_run(input int n);
        for (int i = 0; i < n; i++)
        begin
            // now and then the sender waits until the tracker has emptied
            if (i % 90 == 45)
                drain();
            push_word(random_word());
        end
    endtask

    // directed words under the reset settings (id 0, timing on)
    task directed_words();
        ert_pkg::in_item_t w;
        push_word(next_send());
        push_word(next_send());
        // exact minimum length, plain 50 ms trip
        push_word(mk_reply(16'd0, 16'd0, 8'd0, 4'd5, 16'd28, 32'd100, 20'd200000,
                           32'd100, 20'd250000));
        // duplicate of seq 0 with a usec borrow
        push_word(mk_reply(16'd0, 16'd0, 8'd0, 4'd5, 16'd28, 32'd10, 20'd999999,
                           32'd11, 20'd1));
        // too short, one byte under the minimum and all-zero length
        push_word(mk_reply(16'd1, 16'd0, 8'd0, 4'd15, 16'd67, '0, '0, '0, '0));
        push_word(mk_reply(16'd1, 16'd0, 8'd0, 4'd0, 16'd0, '0, '0, '0, '0));
        // other type
        push_word(mk_reply(16'd1, 16'd0, 8'hFF, 4'd15, 16'hFFFF, '0, '0, '0, '0));
        push_word(mk_reply(16'd1, 16'd0, 8'd8, 4'd0, 16'd64, '0, '0, '0, '0));
        // foreign id
        push_word(mk_reply(16'd1, 16'hFFFF, 8'd0, 4'd0, 16'd8, '0, '0, '0, '0));
        // late timestamp gives a negative trip
        push_word(mk_reply(16'd1, 16'd0, 8'd0, 4'd5, 16'd100, 32'd200, 20'd0,
                           32'd100, 20'd0));
        // seconds wrap with out-of-range usec
        push_word(mk_reply(16'd1, 16'd0, 8'd0, 4'd0, 16'hFFFF, 32'd0, 20'd0,
                           32'hFFFF_FFFF, 20'hFFFFF));
        // largest positive trip
        push_word(mk_reply(16'd1, 16'd0, 8'd0, 4'd0, 16'd8, 32'd0, 20'd0,
                           32'd2147483, 20'd647000));
        // borrow that leaves usec negative, top slot of the map
        push_word(mk_reply(16'hFFFF, 16'd0, 8'd0, 4'd0, 16'd8, 32'd5, 20'hFFFFF,
                           32'd7, 20'd0));
        // alias of slot 0
        push_word(mk_reply(16'd1024, 16'd0, 8'd0, 4'd0, 16'd8, 32'd1, 20'd0,
                           32'd1, 20'd3000));
        push_word(next_send());
        push_word(mk_reply(16'd1026, 16'd0, 8'd0, 4'd0, 16'd8, 32'd1, 20'd0,
                           32'd1, 20'd3000));
        // a send clears a mark that a reply set first
        push_word(mk_reply(16'd3, 16'd0, 8'd0, 4'd0, 16'd8, 32'd1, 20'd0,
                           32'd1, 20'd0));
        push_word(next_send());
        push_word(mk_reply(16'd3, 16'd0, 8'd0, 4'd0, 16'd8, 32'd1, 20'd0,
                           32'd1, 20'd0));
        // send time at the top of the seconds range
        push_word(mk_reply(16'd2, 16'd0, 8'd0, 4'd0, 16'd8, 32'hFFFF_FFFF, 20'd999999,
                           32'd0, 20'd0));
        // send with every payload bit set
        w    = '1;
        w.op = ert_pkg::OP_SEND;
        sends_issued++;
        push_word(w);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        drain();
        write_regs(16'hFFFF, 16'($urandom) | 16'd1);
        random_run(150);

        // timing off: trips stay zero and the figures freeze
        drain();
        write_regs(16'($urandom), 16'($urandom) & 16'hFFFE);
        random_run(100);

        drain();
        write_regs(16'h0000, 16'h0001);
        random_run(120);

        // long stretch with no idling on either side
        drain();
        quiet = 1'b1;
        for (int i = 0; i < 60; i++)
            push_word(random_word());
        quiet = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
hdl/ert_pkg.sv
hdl/ert_trip_pipe.sv
hdl/ert_seen_map.sv
hdl/ert_stats.sv
hdl/echo_reply_tracker.sv
hdl/ert_checker.sv
sim/tb_echo_reply_tracker.sv
